>>> design/pci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_pkg
// shared constants, types and helpers of the palette color indexer
// ----------------------------------------------------------------------------
package pci_pkg;

    localparam int PALETTE_DEPTH_DEF = 1024;
    localparam int CHANNEL_BITS_DEF  = 16;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int BYTES_W    = 3;

    localparam logic [31:0] LIMIT_ONE_BYTE  = 32'd256;
    localparam logic [31:0] LIMIT_TWO_BYTES = 32'd65536;

    localparam logic [BYTES_W-1:0] BYTES_ONE  = 3'd1;
    localparam logic [BYTES_W-1:0] BYTES_TWO  = 3'd2;
    localparam logic [BYTES_W-1:0] BYTES_FOUR = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic hit;
        logic add;
        logic emit;
    } pci_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic match;
        logic last_entry;
        logic out_busy;
    } pci_sts_t;

    function automatic logic [BYTES_W-1:0] bytes_for_count(input logic [31:0] count);
        logic [BYTES_W-1:0] b;
        if (count <= LIMIT_ONE_BYTE)
        begin
            b = BYTES_ONE;
        end
        else if (count <= LIMIT_TWO_BYTES)
        begin
            b = BYTES_TWO;
        end
        else
        begin
            b = BYTES_FOUR;
        end
        return b;
    endfunction

endpackage

>>> design/pci_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_pix_if
// pixel channel: valid/ready handshake with rgb samples and frame marks
// ----------------------------------------------------------------------------
interface pci_pix_if;
    import pci_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                start_image;
    logic                last_pixel;

    modport source (output valid, red, green, blue, start_image, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, start_image, last_pixel, output ready);
endinterface

>>> design/pci_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_res_if
// result channel: valid/ready handshake with palette index and status
// ----------------------------------------------------------------------------
interface pci_res_if;
    import pci_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] color_index;
    logic               is_new_color;
    logic               palette_full;
    logic [COUNT_W-1:0] color_count;
    logic [BYTES_W-1:0] index_bytes;

    modport source (output valid, color_index, is_new_color, palette_full, color_count,
                    index_bytes, input ready);
    modport sink   (input valid, color_index, is_new_color, palette_full, color_count,
                    index_bytes, output ready);
endinterface

>>> design/palette_color_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_indexer
// assigns first-seen palette indices to an rgb pixel stream
// ----------------------------------------------------------------------------
// One pixel transaction in, one result transaction out. The pixel color is
// searched linearly in a palette memory of PALETTE_DEPTH entries, entry by
// entry (memory read, then compare). The scan goes through the single read
// port of the palette memory. Only one pixel is in work at a time, but the
// next pixel is taken while the previous result still waits in the output
// register. start_image empties the palette before its pixel; index_bytes
// is reported on last_pixel only. No clearing pass is needed after reset,
// since only stored entries are read.
// ----------------------------------------------------------------------------
module palette_color_indexer #(
    parameter int PALETTE_DEPTH = pci_pkg::PALETTE_DEPTH_DEF,
    parameter int CHANNEL_BITS  = pci_pkg::CHANNEL_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    pci_pix_if.sink  pix,
    pci_res_if.source res
);
    import pci_pkg::*;

    // command and status between sequencer and datapath
    pci_cmd_t cmd;
    pci_sts_t sts;

    // sequencer: idle, scan the palette, insert on miss, hand the result over
    pci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: pixel register, palette memory, counters, output register
    pci_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .CHANNEL_BITS  (CHANNEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .red          (pix.red),
        .green        (pix.green),
        .blue         (pix.blue),
        .start_image  (pix.start_image),
        .last_pixel   (pix.last_pixel),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .color_index  (res.color_index),
        .is_new_color (res.is_new_color),
        .palette_full (res.palette_full),
        .color_count  (res.color_count),
        .index_bytes  (res.index_bytes)
    );
endmodule

>>> design/pci_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pci_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> design/pci_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_ctrl
// sequencer for palette scan, insert and result hand-off
// ----------------------------------------------------------------------------
module pci_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pci_pkg::pci_sts_t sts,
    output pci_pkg::pci_cmd_t cmd
);
    import pci_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_ADD,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.empty)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_EMIT;
                end
                else if (sts.last_entry)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> design/pci_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_datapath
// pixel register, palette ram, scan counter, entry count and output register
// ----------------------------------------------------------------------------
module pci_datapath #(
    parameter int PALETTE_DEPTH = pci_pkg::PALETTE_DEPTH_DEF,
    parameter int CHANNEL_BITS  = pci_pkg::CHANNEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pci_pkg::SAMPLE_W-1:0] red,
    input  logic [pci_pkg::SAMPLE_W-1:0] green,
    input  logic [pci_pkg::SAMPLE_W-1:0] blue,
    input  logic                         start_image,
    input  logic                         last_pixel,
    input  pci_pkg::pci_cmd_t            cmd,
    output pci_pkg::pci_sts_t            sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pci_pkg::INDEX_W-1:0]  color_index,
    output logic                         is_new_color,
    output logic                         palette_full,
    output logic [pci_pkg::COUNT_W-1:0]  color_count,
    output logic [pci_pkg::BYTES_W-1:0]  index_bytes
);
    import pci_pkg::*;

    localparam int COLOR_W = 3 * CHANNEL_BITS;
    localparam int IDX_W   = $clog2(PALETTE_DEPTH);
    localparam int CNT_W   = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

    logic [COLOR_W-1:0] color_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic               res_new_reg;
    logic               res_full_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_new_reg;
    logic               out_full_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic [BYTES_W-1:0] out_bytes_reg;

    logic [COLOR_W-1:0] rd_data;
    logic               is_full;
    logic               wr_en;
    logic [IDX_W+INDEX_W-1:0] idx_pad;
    logic [CNT_W+COUNT_W-1:0] cnt_pad;

    assign is_full = (count_reg == DEPTH_CNT);
    assign wr_en   = cmd.add && !is_full;

    pci_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (color_reg),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign sts.empty      = (count_reg == '0);
    assign sts.match      = (rd_data == color_reg);
    assign sts.last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // pixel capture, result staging and output register load
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            color_reg <= {red[CHANNEL_BITS-1:0], green[CHANNEL_BITS-1:0],
                          blue[CHANNEL_BITS-1:0]};
            last_reg  <= last_pixel;
        end
        if (cmd.hit)
        begin
            res_idx_reg  <= idx_reg;
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else if (cmd.add)
        begin
            res_idx_reg  <= is_full ? '0 : count_reg[IDX_W-1:0];
            res_new_reg  <= !is_full;
            res_full_reg <= is_full;
        end
        if (cmd.emit)
        begin
            out_idx_reg   <= res_idx_reg;
            out_new_reg   <= res_new_reg;
            out_full_reg  <= res_full_reg;
            out_cnt_reg   <= count_reg;
            out_bytes_reg <= last_reg ? bytes_for_count(32'(count_reg)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                if (start_image)
                begin
                    count_reg <= '0;
                end
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign idx_pad = {{INDEX_W{1'b0}}, out_idx_reg};
    assign cnt_pad = {{COUNT_W{1'b0}}, out_cnt_reg};

    assign out_valid    = out_valid_reg;
    assign color_index  = idx_pad[INDEX_W-1:0];
    assign is_new_color = out_new_reg;
    assign palette_full = out_full_reg;
    assign color_count  = cnt_pad[COUNT_W-1:0];
    assign index_bytes  = out_bytes_reg;

    // palette never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("palette count beyond depth");

    // an insert into a non-full palette grows it by exactly one entry
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow palette");

    // a new color and an overflow never show together
    a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_new_reg && out_full_reg))
        else $error("new color flagged together with overflow");

    // the scan only reads stored entries
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> CNT_W'(idx_reg) < count_reg)
        else $error("palette read beyond stored entries");
endmodule
